>>> rtl/dnsd_pkg.sv
// Shared types and constants for the DNS name decompression unit.
// Used by the interfaces, the controller, the datapath and the top level.
package dnsd_pkg;

  localparam int ADDR_W   = 9;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 9;
  localparam int LEN_W    = 6;
  localparam int NEXT_W   = 10;
  localparam int ERR_W    = 3;
  localparam int HOPS_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic MODE_STORE  = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LABELS = 1'd1;

  localparam logic [HOPS_W-1:0] MAX_HOPS_RESET   = 8'd16;
  localparam logic [LEN_W-1:0]  MAX_LABELS_RESET = 6'd63;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_HOP_LIMIT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_LABEL_LIM = 3'd2;
  localparam logic [ERR_W-1:0] ERR_OUTSIDE   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_RESERVED  = 3'd4;

  localparam logic [1:0] TYPE_LABEL   = 2'b00;
  localparam logic [1:0] TYPE_POINTER = 2'b11;

  typedef struct packed {
    logic             start;
    logic             store;
    logic             read_cur;
    logic             read_next;
    logic             jump;
    logic             emit_label;
    logic             emit_final;
    logic [ERR_W-1:0] err;
  } dnsd_cmd_t;

  typedef struct packed {
    logic cur_oob;
    logic ptr_oob;
    logic label_oob;
    logic byte_zero;
    logic is_ptr;
    logic is_rsv;
    logic hop_lim;
    logic label_lim;
    logic out_free;
  } dnsd_status_t;

endpackage

>>> rtl/dnsd_in_if.sv
// Input item channel: valid/ready handshake with mode, address and data byte.
// Depends on dnsd_pkg.
interface dnsd_in_if import dnsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output mode, output address, output data_byte, input ready);
  modport sink   (input valid, input mode, input address, input data_byte, output ready);
endinterface

>>> rtl/dnsd_out_if.sv
// Result channel: valid/ready handshake with one label or final result.
// Depends on dnsd_pkg.
interface dnsd_out_if import dnsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] label_offset;
  logic [LEN_W-1:0]    label_length;
  logic                is_last;
  logic [NEXT_W-1:0]   next_offset;
  logic [ERR_W-1:0]    error_code;

  modport source (output valid, output label_offset, output label_length, output is_last,
                  output next_offset, output error_code, input ready);
  modport sink   (input valid, input label_offset, input label_length, input is_last,
                  input next_offset, input error_code, output ready);
endinterface

>>> rtl/dnsd_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on dnsd_pkg.
interface dnsd_cfg_if import dnsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/dnsd_ctrl.sv
// Walk controller: sequences loads, label and pointer steps and result emission.
// Depends on dnsd_pkg; drives the datapath through dnsd_cmd_t.
module dnsd_ctrl import dnsd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_mode,
  output logic         item_ready,
  input  dnsd_status_t status,
  output dnsd_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_FETCH   = 2'd1;
  localparam logic [1:0] ST_EXAMINE = 2'd2;
  localparam logic [1:0] ST_PTR_LOW = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic             fin;
    logic [ERR_W-1:0] fin_err;
    fin        = 1'b0;
    fin_err    = ERR_OK;
    cmd        = '0;
    state_next = state;
    item_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_mode == MODE_DECODE) begin
            cmd.start  = 1'b1;
            state_next = ST_FETCH;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        if (status.cur_oob) begin
          fin     = 1'b1;
          fin_err = ERR_OUTSIDE;
        end else begin
          cmd.read_cur = 1'b1;
          state_next   = ST_EXAMINE;
        end
      end
      ST_EXAMINE: begin
        if (status.byte_zero) begin
          fin = 1'b1;
        end else if (status.is_ptr) begin
          if (status.ptr_oob) begin
            fin     = 1'b1;
            fin_err = ERR_OUTSIDE;
          end else if (status.hop_lim) begin
            fin     = 1'b1;
            fin_err = ERR_HOP_LIMIT;
          end else begin
            cmd.read_next = 1'b1;
            state_next    = ST_PTR_LOW;
          end
        end else if (status.is_rsv) begin
          fin     = 1'b1;
          fin_err = ERR_RESERVED;
        end else if (status.label_oob) begin
          fin     = 1'b1;
          fin_err = ERR_OUTSIDE;
        end else if (status.label_lim) begin
          fin     = 1'b1;
          fin_err = ERR_LABEL_LIM;
        end else if (status.out_free) begin
          cmd.emit_label = 1'b1;
          state_next     = ST_FETCH;
        end
      end
      ST_PTR_LOW: begin
        cmd.jump   = 1'b1;
        state_next = ST_FETCH;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.err = fin_err;
    if (fin && status.out_free) begin
      cmd.emit_final = 1'b1;
      state_next     = ST_IDLE;
    end
  end

endmodule

>>> rtl/dnsd_datapath.sv
// Datapath: message buffer, walk cursor, counters, limit registers and result register.
// Depends on dnsd_pkg and the dnsd_cfg_if and dnsd_out_if interfaces; controlled through dnsd_cmd_t.
module dnsd_datapath import dnsd_pkg::*; #(
  parameter int MSG_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  dnsd_cmd_t         cmd,
  output dnsd_status_t      status,
  input  logic [ADDR_W-1:0] item_address,
  input  logic [BYTE_W-1:0] item_data,
  dnsd_cfg_if.sink          cfg,
  dnsd_out_if.source        result
);

  localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int CW = ($clog2(MSG_BYTES + 1) > 14) ? $clog2(MSG_BYTES + 1) : 14;
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] MSG_LIMIT = SW'(MSG_BYTES);

  logic [BYTE_W-1:0] mem [MSG_BYTES];
  logic [BYTE_W-1:0] rdata;
  logic [LEN_W-1:0]  ptr_hi;

  logic [CW-1:0]     cursor;
  logic [CW-1:0]     resume;
  logic              pointer_seen;
  logic [HOPS_W-1:0] hop_count;
  logic [LEN_W-1:0]  label_count;
  logic [HOPS_W-1:0] max_hops;
  logic [LEN_W-1:0]  max_labels;

  logic                out_valid;
  logic [OFFSET_W-1:0] out_offset;
  logic [LEN_W-1:0]    out_length;
  logic                out_last;
  logic [NEXT_W-1:0]   out_next;
  logic [ERR_W-1:0]    out_err;

  logic [SW-1:0] cur_ext;
  logic [SW-1:0] cur_p1;
  logic [SW-1:0] cur_p2;
  logic [SW-1:0] label_end;
  logic [AW-1:0] raddr;
  logic          store_ok;
  logic [CW-1:0] final_next;

  assign cur_ext   = {1'b0, cursor};
  assign cur_p1    = cur_ext + SW'(1);
  assign cur_p2    = cur_ext + SW'(2);
  assign label_end = cur_p1 + SW'(rdata[LEN_W-1:0]);
  assign raddr     = cmd.read_next ? cur_p1[AW-1:0] : cursor[AW-1:0];
  assign store_ok  = SW'(item_address) < MSG_LIMIT;
  assign final_next = pointer_seen ? resume : cur_p1[CW-1:0];

  assign status.cur_oob   = cur_ext >= MSG_LIMIT;
  assign status.ptr_oob   = cur_p1 >= MSG_LIMIT;
  assign status.label_oob = label_end > MSG_LIMIT;
  assign status.byte_zero = (rdata == '0);
  assign status.is_ptr    = (rdata[7:6] == TYPE_POINTER);
  assign status.is_rsv    = (rdata[7:6] != TYPE_POINTER) && (rdata[7:6] != TYPE_LABEL);
  assign status.hop_lim   = hop_count >= max_hops;
  assign status.label_lim = label_count >= max_labels;
  assign status.out_free  = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (cmd.store && store_ok) begin
      mem[AW'(item_address)] <= item_data;
    end
    if (cmd.read_cur || cmd.read_next) begin
      rdata <= mem[raddr];
    end
    if (cmd.read_next) begin
      ptr_hi <= rdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      resume       <= '0;
      pointer_seen <= 1'b0;
      hop_count    <= '0;
      label_count  <= '0;
    end else if (cmd.start) begin
      cursor       <= CW'(item_address);
      resume       <= '0;
      pointer_seen <= 1'b0;
      hop_count    <= '0;
      label_count  <= '0;
    end else begin
      if (cmd.read_next) begin
        hop_count <= hop_count + 1'b1;
        if (!pointer_seen) begin
          resume       <= cur_p2[CW-1:0];
          pointer_seen <= 1'b1;
        end
      end
      if (cmd.jump) begin
        cursor <= CW'({ptr_hi, rdata});
      end
      if (cmd.emit_label) begin
        label_count <= label_count + 1'b1;
        cursor      <= label_end[CW-1:0];
      end
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_hops   <= MAX_HOPS_RESET;
      max_labels <= MAX_LABELS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MAX_HOPS:   max_hops   <= cfg.data;
        CFG_MAX_LABELS: max_labels <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_label || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_label) begin
      out_offset <= cur_p1[OFFSET_W-1:0];
      out_length <= rdata[LEN_W-1:0];
      out_last   <= 1'b0;
      out_next   <= '0;
      out_err    <= ERR_OK;
    end else if (cmd.emit_final) begin
      out_length <= '0;
      out_last   <= 1'b1;
      out_err    <= cmd.err;
      if (cmd.err == ERR_OK) begin
        out_offset <= cursor[OFFSET_W-1:0];
        out_next   <= final_next[NEXT_W-1:0];
      end else begin
        out_offset <= '0;
        out_next   <= '0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.label_offset = out_offset;
  assign result.label_length = out_length;
  assign result.is_last      = out_last;
  assign result.next_offset  = out_next;
  assign result.error_code   = out_err;

endmodule

>>> rtl/dns_name_decompress_unit.sv
// DNS name decompression unit: buffer load and label/pointer walk.
// Decode: accept, then fetch and examine per label, fetch, examine and pointer-low per pointer,
// and fetch and examine for the final result (fetch alone when the cursor lies outside the
// buffer); one memory read port sets the pace. A new input transaction is taken once the final
// result is loaded into the result register. Synchronous reset clears the walk state and result
// valid and loads 16 hops and 63 labels; buffer contents are undefined until written.
module dns_name_decompress_unit import dnsd_pkg::*; #(
  parameter int MSG_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  dnsd_in_if.sink    item,
  dnsd_out_if.source result,
  dnsd_cfg_if.sink   cfg
);

  dnsd_cmd_t    cmd;
  dnsd_status_t status;
  logic         item_ready;

  assign item.ready = item_ready;

  dnsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.mode),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  dnsd_datapath #(
    .MSG_BYTES (MSG_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_address (item.address),
    .item_data    (item.data_byte),
    .cfg          (cfg),
    .result       (result)
  );

endmodule

>>> rtl/dnsd_checker.sv
// Port-level checks on the result channel of the decompression unit.
// Depends on dnsd_pkg; bound to dns_name_decompress_unit below.
module dnsd_checker import dnsd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                valid,
  input logic                ready,
  input logic [OFFSET_W-1:0] label_offset,
  input logic [LEN_W-1:0]    label_length,
  input logic                is_last,
  input logic [NEXT_W-1:0]   next_offset,
  input logic [ERR_W-1:0]    error_code
);

  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(label_offset) && $stable(label_length)
      && $stable(is_last) && $stable(next_offset) && $stable(error_code))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    valid && !is_last |-> error_code == ERR_OK && next_offset == '0 && label_length != '0)
    else $error("label result carries final-only fields");

  assert property (@(posedge clk) disable iff (rst)
    valid && error_code != ERR_OK |-> is_last && label_offset == '0 && label_length == '0
      && next_offset == '0)
    else $error("error result not cleared");

  assert property (@(posedge clk) disable iff (rst)
    valid && is_last |-> label_length == '0)
    else $error("final result has nonzero length");

endmodule

bind dns_name_decompress_unit dnsd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .label_offset (result.label_offset),
  .label_length (result.label_length),
  .is_last      (result.is_last),
  .next_offset  (result.next_offset),
  .error_code   (result.error_code)
);

>>> bench/tb_dns_name_decompress_unit.sv
// Testbench for dns_name_decompress_unit: loads message bytes, decodes names with pointers,
// and checks every label result against a walk of its own over a mirror of the buffer.
// Depends on dnsd_pkg and the dnsd_in_if, dnsd_out_if and dnsd_cfg_if interfaces.
module tb_dns_name_decompress_unit;
  import dnsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MSG_BYTES = 512;

  typedef struct packed {
    logic [OFFSET_W-1:0] label_offset;
    logic [LEN_W-1:0]    label_length;
    logic                is_last;
    logic [NEXT_W-1:0]   next_offset;
    logic [ERR_W-1:0]    error_code;
  } name_label_t;

  logic clk;
  logic rst;

  dnsd_in_if  item();
  dnsd_out_if result();
  dnsd_cfg_if cfg();

  dns_name_decompress_unit #(.MSG_BYTES(MSG_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .cfg(cfg)
  );

  logic [BYTE_W-1:0] msg_mem [MSG_BYTES];
  bit                msg_written [MSG_BYTES];
  logic [HOPS_W-1:0] hop_limit = MAX_HOPS_RESET;
  logic [LEN_W-1:0]  label_limit = MAX_LABELS_RESET;

  name_label_t pending_labels[$];
  name_label_t traced_labels[$];
  int          known_names[$];

  int items_sent = 0;
  int wrong_results = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  function automatic name_label_t mk_label(int off, int len, bit last, int next,
                                           logic [ERR_W-1:0] err);
    name_label_t r;
    r.label_offset = off[OFFSET_W-1:0];
    r.label_length = len[LEN_W-1:0];
    r.is_last      = last;
    r.next_offset  = next[NEXT_W-1:0];
    r.error_code   = err;
    return r;
  endfunction

  function automatic bit end_walk(logic [ERR_W-1:0] err);
    traced_labels = {traced_labels, mk_label(0, 0, 1'b1, 0, err)};
    return 1'b1;
  endfunction

  // Returns 0 when the walk would touch a byte never written.
  function automatic bit trace_name(input logic [ADDR_W-1:0] start);
    int cursor;
    int resume;
    int hops;
    int labels;
    bit via_ptr;
    logic [BYTE_W-1:0] b;
    traced_labels.delete();
    cursor = start;
    resume = 0;
    hops = 0;
    labels = 0;
    via_ptr = 1'b0;
    while (1) begin
      if (cursor >= MSG_BYTES) return end_walk(ERR_OUTSIDE);
      if (!msg_written[cursor]) return 1'b0;
      b = msg_mem[cursor];
      if (b == 8'd0) begin
        if (!via_ptr) resume = cursor + 1;
        traced_labels = {traced_labels, mk_label(cursor, 0, 1'b1, resume, ERR_OK)};
        return 1'b1;
      end
      if (b[7:6] == TYPE_POINTER) begin
        if (cursor + 1 >= MSG_BYTES) return end_walk(ERR_OUTSIDE);
        if (!msg_written[cursor + 1]) return 1'b0;
        if (hops >= int'(hop_limit)) return end_walk(ERR_HOP_LIMIT);
        hops++;
        if (!via_ptr) begin
          resume = cursor + 2;
          via_ptr = 1'b1;
        end
        cursor = {b[5:0], msg_mem[cursor + 1]};
      end else if (b[7:6] != TYPE_LABEL) begin
        return end_walk(ERR_RESERVED);
      end else begin
        if (cursor + 1 + int'(b) > MSG_BYTES) return end_walk(ERR_OUTSIDE);
        if (labels >= int'(label_limit)) return end_walk(ERR_LABEL_LIM);
        traced_labels = {traced_labels, mk_label(cursor + 1, b, 1'b0, 0, ERR_OK)};
        labels++;
        cursor += 1 + int'(b);
      end
    end
    return 1'b0;
  endfunction

  function automatic void flag_result(string why, name_label_t got, name_label_t want);
    wrong_results++;
    if (wrong_results <= 10)
      $display({"%s: got off=%0d len=%0d last=%0b next=%0d err=%0d, ",
                "want off=%0d len=%0d last=%0b next=%0d err=%0d"},
               why, got.label_offset, got.label_length, got.is_last, got.next_offset,
               got.error_code, want.label_offset, want.label_length, want.is_last,
               want.next_offset, want.error_code);
  endfunction

  always @(posedge clk) begin : check_results
    name_label_t got;
    name_label_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      got.label_offset = result.label_offset;
      got.label_length = result.label_length;
      got.is_last      = result.is_last;
      got.next_offset  = result.next_offset;
      got.error_code   = result.error_code;
      if (pending_labels.size() == 0) begin
        flag_result("unexpected result", got, '0);
      end else begin
        want = pending_labels.pop_front();
        if (got.label_offset !== want.label_offset || got.label_length !== want.label_length ||
            got.is_last !== want.is_last || got.next_offset !== want.next_offset ||
            got.error_code !== want.error_code)
          flag_result("label mismatch", got, want);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic mode, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid     <= 1'b1;
    item.mode      <= mode;
    item.address   <= addr;
    item.data_byte <= data;
    do @(posedge clk); while (item.ready !== 1'b1);
    if (mode == MODE_STORE) begin
      msg_mem[addr] = data;
      msg_written[addr] = 1'b1;
    end else begin
      pending_labels = {pending_labels, traced_labels};
    end
    items_sent++;
  endtask

  task automatic store_byte(input int addr, input int data);
    if (addr < MSG_BYTES) send_item(MODE_STORE, addr[ADDR_W-1:0], data[BYTE_W-1:0]);
  endtask

  task automatic decode_name(input int start, output bit sent);
    logic [BYTE_W-1:0] junk;
    junk = $urandom;
    sent = trace_name(start[ADDR_W-1:0]);
    if (sent) send_item(MODE_DECODE, start[ADDR_W-1:0], junk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    if (idx == CFG_MAX_HOPS) hop_limit = val;
    else label_limit = val[LEN_W-1:0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    item.valid <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed_walks();
    int starts[10] = '{0, 5, 6, 7, 8, 10, 12, 448, 500, 511};
    bit sent;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    store_byte(0, 'h01);
    store_byte(2, 'hC0);
    store_byte(3, 'h05);
    store_byte(5, 'h00);
    store_byte(6, 'h40);
    store_byte(7, 'hBF);
    store_byte(8, 'hC0);
    store_byte(9, 'h08);
    store_byte(10, 'hFF);
    store_byte(11, 'hFF);
    store_byte(12, 'h3F);
    store_byte(76, 'h00);
    store_byte(448, 'h3F);
    store_byte(500, 'h3F);
    store_byte(511, 'hC0);
    store_byte(20, 'h01);
    store_byte(22, 'hC0);
    store_byte(23, 'h14);
    foreach (starts[i]) decode_name(starts[i], sent);
  endtask

  task automatic test_register_limits();
    bit sent;
    settle();
    write_reg(CFG_MAX_HOPS, 8'd255);
    write_reg(CFG_MAX_LABELS, 8'd63);
    decode_name(20, sent);
    decode_name(8, sent);
    settle();
    write_reg(CFG_MAX_HOPS, 8'd1);
    write_reg(CFG_MAX_LABELS, 8'd1);
    decode_name(0, sent);
    decode_name(20, sent);
    settle();
    write_reg(CFG_MAX_HOPS, 8'd0);
    write_reg(CFG_MAX_LABELS, 8'd0);
    decode_name(0, sent);
    decode_name(2, sent);
    decode_name(5, sent);
  endtask

  task automatic test_random_names(input int item_goal);
    int phase_end;
    int roll;
    int head;
    int pos;
    int len;
    int ptr;
    bit sent;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_reg(CFG_MAX_HOPS, MAX_HOPS_RESET);
          write_reg(CFG_MAX_LABELS, BYTE_W'(MAX_LABELS_RESET));
        end
        1: begin
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      if (phase != 0) begin
        write_reg(CFG_MAX_HOPS,
                  BYTE_W'(($urandom_range(3) == 0) ? 255 : $urandom_range(20, 1)));
        write_reg(CFG_MAX_LABELS,
                  BYTE_W'(($urandom_range(3) == 0) ? 63 : $urandom_range(8, 1)));
      end
      phase_end = items_sent + item_goal / 4;
      while (items_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          store_byte($urandom_range(511), $urandom_range(255));
        end else if (roll < 18) begin
          decode_name($urandom_range(511), sent);
        end else begin
          head = $urandom_range(511);
          pos = head;
          repeat ($urandom_range(4)) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(63, 1) : $urandom_range(6, 1);
            store_byte(pos, len);
            if ($urandom_range(3) == 0) store_byte(pos + 1, $urandom_range(255));
            pos += 1 + len;
          end
          roll = $urandom_range(99);
          if (roll < 55) begin
            store_byte(pos, 0);
          end else if (roll < 95) begin
            if (roll < 90 && known_names.size() != 0)
              ptr = known_names[$urandom_range(known_names.size() - 1)];
            else
              ptr = $urandom_range(16383);
            store_byte(pos, 'hC0 | (ptr >> 8));
            store_byte(pos + 1, ptr & 'hFF);
          end else begin
            store_byte(pos, ($urandom_range(1) ? 'h40 : 'h80) | $urandom_range(63));
          end
          decode_name(head, sent);
          if (sent && traced_labels[$].error_code == ERR_OK) begin
            known_names = {known_names, head};
            if (known_names.size() > 32) void'(known_names.pop_front());
          end
        end
      end
    end
  endtask

  task automatic test_input_backpressure();
    bit sent;
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 11;
    @(posedge clk);
    hold_request = 400;
    repeat (40)
      decode_name(known_names.size() != 0 ?
                  known_names[$urandom_range(known_names.size() - 1)] : 5, sent);
  endtask

  initial begin : main_sequence
    int guard;
    rst = 1'b1;
    item.valid = 1'b0;
    item.mode = MODE_STORE;
    item.address = '0;
    item.data_byte = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_MAX_HOPS;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_walks();
    test_register_limits();
    test_random_names(440);
    test_input_backpressure();

    @(negedge clk);
    item.valid <= 1'b0;
    guard = 0;
    while (pending_labels.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (wrong_results == 0 && pending_labels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
